### hw/rtl/mcasc_pkg.sv
// Shared types and constants for the mixer channel average/scale/clamp block.
// No dependencies; compile first.
package mcasc_pkg;

    localparam int VAL_W            = 16;  // sample, limits, gain, bias, result
    localparam int SUM_W            = 24;  // running sum and mean
    localparam int CNT_W            = 8;   // window count and divisor
    localparam int PROD_W           = SUM_W + VAL_W;  // mean * gain
    localparam int V_W              = PROD_W + 2;     // signed product + bias
    localparam int CFG_IDX_W        = 3;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLAMP_MIN     = 3'd0,
        REG_CLAMP_MAX     = 3'd1,
        REG_GAIN          = 3'd2,
        REG_BIAS          = 3'd3,
        REG_INVERT_MODE   = 3'd4,
        REG_AVERAGE_COUNT = 3'd5
    } mcasc_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL_GO,
        S_MUL,
        S_BIAS,
        S_LOAD
    } mcasc_state_t;

    // Handshake between the sequencer and a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } mcasc_unit_stat_t;

endpackage

### hw/rtl/mcasc_ifs.sv
// Valid/ready channel interfaces: sample in, mixed value out, config writes.
// Depends on mcasc_pkg.
interface mcasc_sample_if
    import mcasc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mcasc_value_if
    import mcasc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] mixed_value;

    modport source (output valid, output mixed_value, input ready);
    modport sink   (input valid, input mixed_value, output ready);
endinterface

interface mcasc_cfg_if
    import mcasc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VAL_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/mcasc_div.sv
// Restoring bit-serial divider: SUM_W-bit dividend by CNT_W-bit divisor,
// one quotient bit per cycle. Depends on mcasc_pkg.
module mcasc_div
    import mcasc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output mcasc_unit_stat_t stat,
    output logic [SUM_W-1:0] quotient
);
    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
endmodule

### hw/rtl/mcasc_mul.sv
// Shift-add serial multiplier: SUM_W-bit mean times VAL_W-bit gain,
// one gain bit per cycle. Depends on mcasc_pkg.
module mcasc_mul
    import mcasc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  multiplicand,
    input  logic [VAL_W-1:0]  multiplier,
    output mcasc_unit_stat_t  stat,
    output logic [PROD_W-1:0] product
);
    localparam int STEP_W = $clog2(VAL_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]  mcand_reg, mcand_next;
    logic [SUM_W-1:0]  hi_reg, hi_next;
    logic [VAL_W-1:0]  lo_reg, lo_next;

    logic [SUM_W:0]    psum;

    always_comb
    begin
        psum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            mcand_next = multiplicand;
            hi_next    = '0;
            lo_next    = multiplier;
        end
        else if (busy_reg)
        begin
            // add then shift the whole {hi, lo} pair right by one
            hi_next  = psum[SUM_W:1];
            lo_next  = {psum[0], lo_reg[VAL_W-1:1]};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(VAL_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = {hi_reg, lo_reg};
endmodule

### hw/rtl/mixer_channel_average_scale_clamp_core.sv
// Top level of one mixer channel: window averaging, gain, bias, clamp, invert.
// Depends on mcasc_pkg, mcasc_ifs, mcasc_div and mcasc_mul.
//
//  channel    modport  beat payload            notes
//  ---------  -------  ----------------------  ------------------------------
//  sample_ch  sink     sample[15:0]            one raw reading per beat
//  mixed_ch   source   mixed_value[15:0]       zero or one beat per sample
//  cfg        sink     index[2:0], data[15:0]  register write, always ready
//
// A sample that does not close a window is absorbed and leaves the sequencer idle.
// Pass-through (count 0 or 1): the sample runs through the 16-step serial
// multiplier, then the bias and load states, before the next sample is taken.
// Closing a window runs the 24-step serial divider first.
// One sample in flight; sample_ch.ready only while the sequencer is idle. The
// output register frees the input while a result waits; a stalled mixed_ch
// holds the load state. Reset is asynchronous, active low, no clearing pass.
module mixer_channel_average_scale_clamp_core
    import mcasc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    mcasc_sample_if.sink   sample_ch,
    mcasc_value_if.source  mixed_ch,
    mcasc_cfg_if.sink      cfg
);
    // only the low SAMPLE_WIDTH bits of a sample count
    localparam int                USED_W      = (SAMPLE_WIDTH < VAL_W) ? SAMPLE_WIDTH : VAL_W;
    localparam logic [VAL_W-1:0]  SAMPLE_MASK = VAL_W'((64'd1 << USED_W) - 64'd1);

    // configuration registers
    logic [VAL_W-1:0]        clamp_min_reg;
    logic [VAL_W-1:0]        clamp_max_reg;
    logic [VAL_W-1:0]        gain_reg;
    logic signed [VAL_W-1:0] bias_reg;
    logic                    invert_mode_reg;
    logic [CNT_W-1:0]        average_count_reg;

    // sequencer and datapath
    mcasc_state_t      state_reg, state_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  mean_reg, mean_next;
    logic signed [V_W-1:0] v_reg, v_next;
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_value_reg, out_value_next;

    logic              in_beat;
    logic              out_beat;
    logic [VAL_W-1:0]  s_masked;
    logic [SUM_W-1:0]  sum_plus;
    logic [CNT_W-1:0]  cnt_plus;
    logic              div_start;
    logic              mul_start;
    logic [VAL_W-1:0]  clamped;
    logic signed [V_W-1:0] min_ext;
    logic signed [V_W-1:0] max_ext;

    mcasc_unit_stat_t  div_stat;
    mcasc_unit_stat_t  mul_stat;
    logic [SUM_W-1:0]  div_quotient;
    logic [PROD_W-1:0] mul_product;

    assign sample_ch.ready = (state_reg == S_IDLE);
    assign in_beat         = sample_ch.valid && sample_ch.ready;
    assign out_beat        = mixed_ch.valid && mixed_ch.ready;
    assign mixed_ch.valid       = out_valid_reg;
    assign mixed_ch.mixed_value = out_value_reg;
    assign cfg.ready       = 1'b1;

    // ---------------- configuration writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_min_reg     <= '0;
            clamp_max_reg     <= '1;
            gain_reg          <= VAL_W'(1);
            bias_reg          <= '0;
            invert_mode_reg   <= 1'b0;
            average_count_reg <= CNT_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_CLAMP_MIN:     clamp_min_reg     <= cfg.data;
                REG_CLAMP_MAX:     clamp_max_reg     <= cfg.data;
                REG_GAIN:          gain_reg          <= cfg.data;
                REG_BIAS:          bias_reg          <= cfg.data;
                REG_INVERT_MODE:   invert_mode_reg   <= cfg.data[0];
                REG_AVERAGE_COUNT: average_count_reg <= cfg.data[CNT_W-1:0];
                default:           ;  // unknown index: ignored
            endcase
        end
    end

    // ---------------- serial units ----------------
    mcasc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_plus),
        .divisor  (average_count_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    mcasc_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (mean_reg),
        .multiplier   (gain_reg),
        .stat         (mul_stat),
        .product      (mul_product)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg      <= mean_next;
        v_reg         <= v_next;
        out_value_reg <= out_value_next;
    end

    always_comb
    begin
        s_masked = sample_ch.sample & SAMPLE_MASK;
        sum_plus = sum_reg + SUM_W'(s_masked);   // wraps at 2^SUM_W
        cnt_plus = cnt_reg + CNT_W'(1);

        // clamp: when the limits cross, values below the lower limit give it, all others the upper
        min_ext = $signed({{(V_W-VAL_W){1'b0}}, clamp_min_reg});
        max_ext = $signed({{(V_W-VAL_W){1'b0}}, clamp_max_reg});
        if (v_reg < min_ext)
            clamped = clamp_min_reg;
        else if (v_reg > max_ext)
            clamped = clamp_max_reg;
        else
            clamped = v_reg[VAL_W-1:0];

        state_next     = state_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        mean_next      = mean_reg;
        v_next         = v_reg;
        out_valid_next = out_valid_reg && !out_beat;
        out_value_next = out_value_reg;
        div_start      = 1'b0;
        mul_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    if (average_count_reg <= CNT_W'(1))
                    begin
                        // pass-through: sample is the mean, window cleared
                        sum_next   = '0;
                        cnt_next   = '0;
                        mean_next  = SUM_W'(s_masked);
                        state_next = S_MUL_GO;
                    end
                    else if (cnt_plus >= average_count_reg)
                    begin
                        sum_next   = '0;
                        cnt_next   = '0;
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        sum_next = sum_plus;
                        cnt_next = cnt_plus;
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    mean_next  = div_quotient;
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_stat.done)
                    state_next = S_BIAS;
            end
            S_BIAS:
            begin
                v_next = $signed({2'b00, mul_product})
                       + V_W'(bias_reg);
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!out_valid_reg || mixed_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = invert_mode_reg ? (clamp_max_reg - clamped) : clamped;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- assertions ----------------
    // an empty window holds no partial sum
    a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (sum_reg == '0))
        else $error("running sum nonzero with empty window");

    // the two serial units never run at once
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_stat.busy && mul_stat.busy))
        else $error("divider and multiplier busy together");

    // a started divide is running in the next cycle
    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (div_stat.busy && state_reg == S_DIV))
        else $error("divider failed to start");

    // no sample is taken while a unit is busy
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        sample_ch.ready |-> !(div_stat.busy || mul_stat.busy))
        else $error("input ready while arithmetic busy");
endmodule

### tb/mixer_channel_average_scale_clamp_core_tb.sv
// Testbench for mixer_channel_average_scale_clamp_core: directed and random sample beats
// checked against an in-bench model of window averaging, gain, bias, clamp and invert.
// Depends on mcasc_pkg, mcasc_ifs and the core RTL.
`timescale 1ns / 100ps

module mixer_channel_average_scale_clamp_core_tb;
    import mcasc_pkg::*;

    localparam int SETTLE_CYCLES = 100;     // margin past the worst closing-window path
    localparam int DRAIN_CYCLES  = 100;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_ITEMS  = 650;
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off for back-pressure

    // Indexes 6 and 7 fit the index field but map to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } rx_style_t;

    // ------------------------------------------------------------------
    // Expected-value board: own copy of registers and window state,
    // a queue of mixed values still owed by the core.
    // ------------------------------------------------------------------
    class mixed_value_board;
        logic [VAL_W-1:0]        clamp_lo;
        logic [VAL_W-1:0]        clamp_hi;
        logic [VAL_W-1:0]        gain;
        logic signed [VAL_W-1:0] bias;
        bit                      invert;
        logic [CNT_W-1:0]        window_len;
        logic [SUM_W-1:0]        win_sum;
        logic [CNT_W-1:0]        win_fill;
        logic [VAL_W-1:0]        owed_values[$];
        int unsigned             faults;
        int unsigned             checked;

        function new();
            clamp_lo   = '0;
            clamp_hi   = '1;
            gain       = 16'd1;
            bias       = '0;
            invert     = 1'b0;
            window_len = 8'd1;
            win_sum    = '0;
            win_fill   = '0;
            faults     = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] value);
            case (idx)
                REG_CLAMP_MIN:     clamp_lo   = value;
                REG_CLAMP_MAX:     clamp_hi   = value;
                REG_GAIN:          gain       = value;
                REG_BIAS:          bias       = value;
                REG_INVERT_MODE:   invert     = value[0];
                REG_AVERAGE_COUNT: window_len = value[CNT_W-1:0];
                default:           ;
            endcase
        endfunction

        // mean * gain + bias, clamp (when crossed: below lower gives lower, else upper), optional invert
        function logic [VAL_W-1:0] scale_clamp(logic [SUM_W-1:0] mean);
            longint           v;
            longint           c;
            logic [VAL_W-1:0] cl;
            v = longint'(mean) * longint'(gain) + longint'(bias);
            if (v < longint'(clamp_lo))
                c = longint'(clamp_lo);
            else if (v > longint'(clamp_hi))
                c = longint'(clamp_hi);
            else
                c = v;
            cl = c[VAL_W-1:0];
            if (invert)
                return clamp_hi - cl;   // wraps when limits are crossed
            return cl;
        endfunction

        function void note_sample(logic [VAL_W-1:0] s);
            logic [SUM_W-1:0] mean;
            if (window_len <= CNT_W'(1))
            begin
                win_sum  = '0;
                win_fill = '0;
                owed_values.push_back(scale_clamp({{(SUM_W-VAL_W){1'b0}}, s}));
                return;
            end
            win_sum  = win_sum + SUM_W'(s);
            win_fill = win_fill + CNT_W'(1);
            if (win_fill < window_len)
                return;
            mean     = win_sum / SUM_W'(window_len);
            win_sum  = '0;
            win_fill = '0;
            owed_values.push_back(scale_clamp(mean));
        endfunction

        function void check_value(logic [VAL_W-1:0] got);
            logic [VAL_W-1:0] want;
            if (owed_values.size() == 0)
            begin
                if (faults < 10)
                    $display("mixed_value %h arrived with no value owed", got);
                faults++;
                return;
            end
            want = owed_values.pop_front();
            checked++;
            if (got !== want)
            begin
                if (faults < 10)
                    $display("mixed_value mismatch on beat %0d: expected %h, actual %h",
                             checked, want, got);
                faults++;
            end
        endfunction

        function int pending();
            return owed_values.size();
        endfunction

        function void close_out();
            if (owed_values.size() != 0)
            begin
                if (faults < 10)
                    $display("%0d mixed values never arrived", owed_values.size());
                faults += owed_values.size();
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mcasc_sample_if smp_bus ();
    mcasc_value_if  val_bus ();
    mcasc_cfg_if    cfg_bus ();

    mixed_value_board board = new();

    // Receiver controls, set by the main sequence, consumed by the sink process
    rx_style_t rx_style    = RX_ALWAYS;
    int        rx_hold_len = 0;

    // Sender burst state
    int burst_left = 0;
    bit gaps_on    = 1'b0;

    int unsigned cycle_count = 0;

    always #5 clk = ~clk;

    mixer_channel_average_scale_clamp_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (smp_bus),
        .mixed_ch  (val_bus),
        .cfg       (cfg_bus)
    );

    // Watchdog: a hang anywhere ends the run as a failure
    initial
    begin : watchdog
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("mixer_channel_average_scale_clamp_core regression: fail");
                $finish;
            end
        end
    end

    // Result sink: checks every accepted mixed_value beat, then picks ready for the
    // next edge. Values read right after the edge are the pre-edge ones.
    initial
    begin : value_sink
        int unsigned rx_tick;
        rx_tick = 0;
        val_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_tick++;
            if (rst_n && val_bus.valid && val_bus.ready)
                board.check_value(val_bus.mixed_value);
            if (rx_hold_len != 0)
            begin
                // long hold-off: the core fills its output register and stalls input
                rx_hold_len--;
                val_bus.ready <= 1'b0;
            end
            else
            begin
                case (rx_style)
                    RX_ALWAYS:  val_bus.ready <= 1'b1;
                    RX_RANDOM:  val_bus.ready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: val_bus.ready <= ((rx_tick % 5) != 0) &&
                                                 (((rx_tick / 16) % 4) != 3);
                    default:    val_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. All called at a rising edge; inputs change by NBA only.
    // valid stays high across back-to-back beats and is lowered by the
    // caller once a burst or a block of writes is done.
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        board.write_reg(idx, value);
    endtask

    task automatic cfg_done();
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [VAL_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(0, 30) : 0;
            if (gap != 0)
            begin
                smp_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        smp_bus.valid  <= 1'b1;
        smp_bus.sample <= value;
        @(posedge clk);
        while (!smp_bus.ready)
            @(posedge clk);
        board.note_sample(value);
    endtask

    task automatic end_burst();
        smp_bus.valid <= 1'b0;
        burst_left = 0;
    endtask

    // Idle point for register writes: all owed values in, then latency margin
    task automatic settle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return VAL_W'($urandom_range(0, 15));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_limit(input bit upper);
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return VAL_W'($urandom);
            default: return upper ? VAL_W'($urandom_range(60000, 65535))
                                  : VAL_W'($urandom_range(0, 1000));
        endcase
    endfunction

    // Random register set; limits mostly ordered, sometimes crossed
    task automatic random_settings(input bit short_window);
        logic [VAL_W-1:0]     lo;
        logic [VAL_W-1:0]     hi;
        logic [VAL_W-1:0]     tmp;
        logic [VAL_W-1:0]     g;
        logic [VAL_W-1:0]     b;
        logic [CNT_W-1:0]     n;
        logic [CFG_IDX_W-1:0] spare;
        lo = pick_limit(1'b0);
        hi = pick_limit(1'b1);
        if (lo > hi && $urandom_range(0, 3) != 0)
        begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        case ($urandom_range(0, 5))
            0:       g = 16'h0000;
            1:       g = 16'hFFFF;
            2:       g = VAL_W'($urandom);
            default: g = VAL_W'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 5))
            0:       b = 16'h8000;
            1:       b = 16'h7FFF;
            2:       b = VAL_W'($urandom);
            default:
            begin
                b = VAL_W'($urandom_range(0, 400));
                b = b - 16'd200;
            end
        endcase
        if (short_window)
            n = 8'd3;       // lowers the count under a well-filled window
        else
        begin
            case ($urandom_range(0, 9))
                0:       n = 8'd0;
                1:       n = 8'd1;
                2:       n = CNT_W'($urandom_range(9, 40));
                default: n = CNT_W'($urandom_range(2, 8));
            endcase
        end
        cfg_write(REG_CLAMP_MIN, lo);
        cfg_write(REG_CLAMP_MAX, hi);
        cfg_write(REG_GAIN, g);
        cfg_write(REG_BIAS, b);
        cfg_write(REG_INVERT_MODE, VAL_W'($urandom_range(0, 1)));
        cfg_write(REG_AVERAGE_COUNT, {{(VAL_W-CNT_W){1'b0}}, n});
        if ($urandom_range(0, 3) == 0)
        begin
            spare = ($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
            cfg_write(spare, VAL_W'($urandom));
        end
        cfg_done();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int phase;
        int sent;
        int n;
        smp_bus.valid  <= 1'b0;
        smp_bus.sample <= '0;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.index  <= '0;
        cfg_bus.data   <= '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: pass-through, unity gain, full range; field extremes
        rx_style = RX_RANDOM;
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        end_burst();
        settle();

        // Max gain and bias: clamp at the top for nonzero samples
        cfg_write(REG_GAIN, 16'hFFFF);
        cfg_write(REG_BIAS, 16'h7FFF);
        cfg_done();
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0001);
        end_burst();
        settle();

        // Zero gain, most negative bias: clamp at the bottom of a narrow range
        cfg_write(REG_GAIN, 16'h0000);
        cfg_write(REG_BIAS, 16'h8000);
        cfg_write(REG_CLAMP_MIN, 16'd100);
        cfg_write(REG_CLAMP_MAX, 16'd200);
        cfg_done();
        send_sample(16'd1234);
        end_burst();
        settle();

        // Crossed limits with inverted output: both limits are hit, inversion wraps
        cfg_write(REG_CLAMP_MIN, 16'd60000);
        cfg_write(REG_CLAMP_MAX, 16'd10);
        cfg_write(REG_GAIN, 16'd1);
        cfg_write(REG_BIAS, 16'd0);
        cfg_write(REG_INVERT_MODE, 16'd1);
        cfg_done();
        send_sample(16'd5);
        send_sample(16'hFFFF);
        send_sample(16'd30000);
        end_burst();
        settle();

        // Count of zero passes through
        cfg_write(REG_CLAMP_MIN, 16'h0000);
        cfg_write(REG_CLAMP_MAX, 16'hFFFF);
        cfg_write(REG_INVERT_MODE, 16'd0);
        cfg_write(REG_AVERAGE_COUNT, 16'd0);
        cfg_done();
        send_sample(16'd123);
        end_burst();
        settle();

        // Window of four closes once, then two beats stay in an open window
        cfg_write(REG_AVERAGE_COUNT, 16'd4);
        cfg_done();
        send_sample(16'hFFFF);
        send_sample(16'hFFFF);
        send_sample(16'hFFFE);
        send_sample(16'h0003);
        send_sample(16'd1000);
        send_sample(16'd2000);
        end_burst();
        settle();

        // Count lowered under an open window: next beat closes it at once
        cfg_write(REG_AVERAGE_COUNT, 16'd2);
        cfg_done();
        send_sample(16'd3000);
        send_sample(16'd7);
        end_burst();
        settle();

        // Back to pass-through: clears the open window
        cfg_write(REG_AVERAGE_COUNT, 16'd1);
        cfg_done();
        send_sample(16'd9);
        end_burst();
        settle();

        // Writes to unmapped indexes change nothing
        cfg_write(REG_SPARE_LO, 16'hFFFF);
        cfg_write(REG_SPARE_HI, 16'hFFFF);
        cfg_done();
        send_sample(16'd42);
        end_burst();
        settle();

        // Random phases. Phase 2 fills a full 255-sample window and leaves a
        // large open one; phase 3 then lowers the count so the mean exceeds
        // 16 bits. Phases 1 and 6 open with a long receiver hold-off.
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            rx_style = rx_style_t'($urandom_range(0, 3));
            gaps_on  = ($urandom_range(0, 2) != 0);
            if (phase == 2)
            begin
                cfg_write(REG_CLAMP_MIN, 16'h0000);
                cfg_write(REG_CLAMP_MAX, 16'hFFFF);
                cfg_write(REG_GAIN, 16'd1);
                cfg_write(REG_BIAS, 16'd0);
                cfg_write(REG_INVERT_MODE, VAL_W'($urandom_range(0, 1)));
                cfg_write(REG_AVERAGE_COUNT, 16'd255);
                cfg_done();
                n = 255 + 120;
            end
            else
            begin
                random_settings(phase == 3);
                n = $urandom_range(15, 45);
            end
            if (phase == 1 || phase == 6)
            begin
                rx_hold_len = HOLD_CYCLES;
                gaps_on     = 1'b0;
            end
            repeat (n) send_sample(pick_sample());
            end_burst();
            settle();
            sent += n;
            phase++;
        end

        // Drain: nothing owed, then watch for stray beats
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        board.close_out();
        if (board.faults == 0)
            $display("mixer_channel_average_scale_clamp_core regression: pass");
        else
            $display("mixer_channel_average_scale_clamp_core regression: fail");
        $finish;
    end

endmodule
